// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_ONEHOT0(lbl, clk, rstn, vec) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) $onehot0(vec)) \
    else $error("assertion failed: more than one bit set");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ONEHOT0(lbl, clk, rstn, vec)
`endif

`endif

// ===== rtl/qwcg_pkg.sv =====
// ---------------------------------------------------------------------------
// qwcg_pkg
// Shared types and field layout for the qubit-wise commuting grouper.
// ---------------------------------------------------------------------------
package qwcg_pkg;

  localparam int TERM_W = 32;   // width of an X or Z mask field
  localparam int ID_W   = 16;   // term index width
  localparam int GIDX_W = 4;    // reported group index width

  // input tdata layout
  localparam int X_LSB    = 0;
  localparam int Z_LSB    = TERM_W;
  localparam int ID_LSB   = 2 * TERM_W;
  localparam int S_DATA_W = 80;

  // output tdata layout: placed_id, group_index, zero fill
  localparam int M_DATA_W = 24;
  localparam int M_USER_W = 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // what a cell reports in the cycle it holds the request token
  typedef struct packed {
    logic hit;      // cell took the term
    logic opened;   // cell was free and opened for it
  } claim_t;

endpackage

// ===== rtl/qwcg_cell.sv =====
// ---------------------------------------------------------------------------
// qwcg_cell
// One group slot: X/Z bases, open flag, fit check and token hand-off.
// ---------------------------------------------------------------------------
module qwcg_cell #(
  parameter int W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             tok_i,
  input  logic [W-1:0]     term_x_i,
  input  logic [W-1:0]     term_z_i,
  output logic             tok_o,
  output qwcg_pkg::claim_t claim_o
);

  logic         open_q, open_d;
  logic         tok_q, tok_d;
  logic [W-1:0] x_q, x_d;
  logic [W-1:0] z_q, z_d;
  logic         fit;

  // qubit-wise conflict against the accumulated bases
  assign fit = (((term_x_i & z_q) ^ (term_z_i & x_q)) == '0);

  always_comb begin
    claim_o.hit    = tok_i && (!open_q || fit);
    claim_o.opened = tok_i && !open_q;
    tok_d          = tok_i && !claim_o.hit;
    open_d         = open_q;
    x_d            = x_q;
    z_d            = z_q;
    if (clear_i) begin
      open_d = 1'b0;
    end else if (claim_o.opened) begin
      open_d = 1'b1;
      x_d    = term_x_i;
      z_d    = term_z_i;
    end else if (claim_o.hit) begin
      x_d = x_q | term_x_i;
      z_d = z_q | term_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      open_q <= open_d;
      tok_q  <= tok_d;
    end
  end

  // bases are only read while open_q is set
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    z_q <= z_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/qubit_wise_commuting_first_fit_grouper.sv =====
// A term placed in group g gives its result once the token has reached cell g;
// an overflow result comes once the token has passed all MAX_GROUPS cells.
// One term at a time: no new term is taken until the walk of the last one ends,
// the token walking the cell row one cell per cycle until a group takes the term.
// Reset (rst_ni low, async): all groups closed, no request in flight, output empty.
// ---------------------------------------------------------------------------
// qubit_wise_commuting_first_fit_grouper
// First-fit grouping of Pauli terms into qubit-wise commuting groups. A row
// of group cells holds the X/Z bases; a token walks the row and the first
// open cell without a conflict, or the first free cell, takes the term.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qubit_wise_commuting_first_fit_grouper #(
  parameter int QUBITS     = 32,
  parameter int MAX_GROUPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] term_x, [63:32] term_z, [79:64] term_id
  input  logic [qwcg_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] new_set
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] placed_id, [19:16] group_index, [23:20] zero
  output logic [qwcg_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [0] opened_group, [1] overflow
  output logic [qwcg_pkg::M_USER_W-1:0] m_axis_tuser
);

  // stored qubits: mask bits at or above QUBITS never reach the cells
  localparam int QW = (QUBITS < qwcg_pkg::TERM_W) ? QUBITS : qwcg_pkg::TERM_W;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int PAD_W = qwcg_pkg::M_DATA_W - qwcg_pkg::ID_W - qwcg_pkg::GIDX_W;

  qwcg_pkg::state_e state_q, state_d;

  logic                      accept;
  logic                      tok0_q;
  logic [GW-1:0]             idx_q, idx_d;
  logic [QW-1:0]             term_x_q, term_z_q;
  logic [qwcg_pkg::ID_W-1:0] id_q;
  logic                      clear;

  // token chain: tok[0] enters cell 0, tok[MAX_GROUPS] means no slot left
  logic [MAX_GROUPS:0]       tok;
  logic [MAX_GROUPS-1:0]     hit_vec, open_vec;
  qwcg_pkg::claim_t          claim [MAX_GROUPS];

  logic                      any_hit, any_open, ovf, done;

  // result word as it will appear on the port
  logic [qwcg_pkg::M_DATA_W-1:0] res_data;
  logic [qwcg_pkg::M_USER_W-1:0] res_user;

  // output register plus one skid entry
  logic                          out_vld_q, pend_vld_q;
  logic [qwcg_pkg::M_DATA_W-1:0] out_data_q, pend_data_q;
  logic [qwcg_pkg::M_USER_W-1:0] out_user_q, pend_user_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign clear  = accept && s_axis_tuser;

  // ---- controller --------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    s_axis_tready = 1'b0;
    case (state_q)
      qwcg_pkg::ST_IDLE: begin
        // one term at a time; hold off while a result still sits in the skid
        s_axis_tready = !pend_vld_q;
        if (s_axis_tvalid && !pend_vld_q) begin
          state_d = qwcg_pkg::ST_RUN;
          idx_d   = '0;
        end
      end
      qwcg_pkg::ST_RUN: begin
        // idx_q tracks which cell holds the token this cycle
        idx_d = idx_q + GW'(1);
        if (done) begin
          state_d = qwcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qwcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qwcg_pkg::ST_IDLE;
      tok0_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      tok0_q  <= accept;
      idx_q   <= idx_d;
    end
  end

  // term broadcast to every cell
  always_ff @(posedge clk_i) begin
    if (accept) begin
      term_x_q <= s_axis_tdata[qwcg_pkg::X_LSB +: QW];
      term_z_q <= s_axis_tdata[qwcg_pkg::Z_LSB +: QW];
      id_q     <= s_axis_tdata[qwcg_pkg::ID_LSB +: qwcg_pkg::ID_W];
    end
  end

  // ---- cell row ------------------------------------------------------------
  assign tok[0] = tok0_q;

  for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
    qwcg_cell #(
      .W (QW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clear),
      .tok_i    (tok[g]),
      .term_x_i (term_x_q),
      .term_z_i (term_z_q),
      .tok_o    (tok[g+1]),
      .claim_o  (claim[g])
    );
    assign hit_vec[g]  = claim[g].hit;
    assign open_vec[g] = claim[g].opened;
  end

  assign any_hit  = |hit_vec;
  assign any_open = |open_vec;
  assign ovf      = tok[MAX_GROUPS];   // token fell off the end: table full
  assign done     = (state_q == qwcg_pkg::ST_RUN) && (any_hit || ovf);

  always_comb begin
    res_data = {{PAD_W{1'b0}},
                any_hit ? qwcg_pkg::GIDX_W'(idx_q) : {qwcg_pkg::GIDX_W{1'b0}},
                id_q};
    res_user = {ovf && !any_hit, any_open};
  end

  // ---- result register with skid -----------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q  <= pend_vld_q || done;
        pend_vld_q <= 1'b0;
      end else if (done) begin
        pend_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      if (pend_vld_q) begin
        out_data_q <= pend_data_q;
        out_user_q <= pend_user_q;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end else if (done) begin
      pend_data_q <= res_data;
      pend_user_q <= res_user;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---- assertions --------------------------------------------------------
  // only the token holder may claim
  `ASSERT_ONEHOT0(a_single_claim, clk_i, rst_ni, hit_vec)
  // an accepted request starts a walk of the row
  `ASSERT_CLK(a_accept_runs, clk_i, rst_ni, accept |=> (state_q == qwcg_pkg::ST_RUN && !s_axis_tready))
  // a skid entry only exists behind a full output register
  `ASSERT_CLK(a_skid_order, clk_i, rst_ni, pend_vld_q |-> out_vld_q)
  // every finished walk shows up on the result side
  `ASSERT_CLK(a_done_shows, clk_i, rst_ni, done |=> m_axis_tvalid)

endmodule

// ===== tb/sv/tb_qubit_wise_commuting_first_fit_grouper.sv =====
// ---------------------------------------------------------------------------
// tb_qubit_wise_commuting_first_fit_grouper
// Streams Pauli terms into the first-fit grouper and checks every placement
// against a group table kept alongside the block, under random source gaps
// and sink stalls, including one long sink hold-off that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_qubit_wise_commuting_first_fit_grouper;

  localparam int TERM_W   = qwcg_pkg::TERM_W;
  localparam int ID_W     = qwcg_pkg::ID_W;
  localparam int GIDX_W   = qwcg_pkg::GIDX_W;
  localparam int S_DATA_W = qwcg_pkg::S_DATA_W;
  localparam int M_DATA_W = qwcg_pkg::M_DATA_W;
  localparam int M_USER_W = qwcg_pkg::M_USER_W;

  localparam int QUBITS       = 32;
  localparam int MAX_GROUPS   = 16;
  localparam int TERM_BUDGET  = 450;
  localparam int HOLD_CYCLES  = 80;    // long sink hold-off for the fill-up test
  localparam int IDLE_LIMIT   = 2000;  // cycles with no request or result moving
  localparam logic [TERM_W-1:0] QUBIT_MASK =
    (QUBITS >= TERM_W) ? '1 : ((TERM_W'(1) << QUBITS) - 1);

  // one Pauli term as it travels on the request stream
  typedef struct {
    logic [TERM_W-1:0] x;
    logic [TERM_W-1:0] z;
    logic [ID_W-1:0]   id;
    logic              new_set;
  } pauli_term_t;

  // one placement as it comes back on the result stream
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [GIDX_W-1:0] gidx;
    logic              opened;
    logic              overflow;
  } placement_t;

  // how the random part shapes a term's masks
  typedef enum int {
    MIX_SPARSE,   // one to three single-qubit Paulis
    MIX_WINDOW,   // dense Paulis in a 4-qubit window
    MIX_DENSE,    // full random masks, nearly always conflicting
    MIX_EXTREME   // all-zero, all-one, top or bottom bit only
  } term_style_e;

  // sink readiness patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;

  // shadow group table
  logic [TERM_W-1:0] basis_x [MAX_GROUPS];
  logic [TERM_W-1:0] basis_z [MAX_GROUPS];
  int                groups_open = 0;

  placement_t pending_placements[$];   // placements still owed by the block
  int         fail_count = 0;
  int         terms_sent = 0;

  // source pacing
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // sink hold-off handshake between the test thread and the sink process
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  rx_mode_e rx_mode   = RX_ALWAYS;
  int       mode_left = 0;

  int idle_cycles = 0;

  qubit_wise_commuting_first_fit_grouper #(
    .QUBITS     (QUBITS),
    .MAX_GROUPS (MAX_GROUPS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Placement predictor: first open group without a per-qubit clash takes
  // the term, else the next free slot opens, else overflow and no change.
  // ------------------------------------------------------------------------
  function automatic placement_t place_term(pauli_term_t t);
    logic [TERM_W-1:0] tx;
    logic [TERM_W-1:0] tz;
    placement_t        p;
    int                hit;
    tx  = t.x & QUBIT_MASK;
    tz  = t.z & QUBIT_MASK;
    hit = -1;
    p.id       = t.id;
    p.gidx     = '0;
    p.opened   = 1'b0;
    p.overflow = 1'b0;
    if (t.new_set) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        basis_x[g] = '0;
        basis_z[g] = '0;
      end
      groups_open = 0;
    end
    for (int g = 0; g < groups_open; g++) begin
      if (hit < 0 && ((tx & basis_z[g]) ^ (tz & basis_x[g])) == '0) hit = g;
    end
    if (hit < 0) begin
      if (groups_open < MAX_GROUPS) begin
        hit          = groups_open;
        basis_x[hit] = '0;
        basis_z[hit] = '0;
        groups_open++;
        p.opened     = 1'b1;
      end else begin
        p.overflow = 1'b1;   // table full: state untouched, index reads 0
      end
    end
    if (hit >= 0) begin
      basis_x[hit] |= tx;
      basis_z[hit] |= tz;
      p.gidx        = GIDX_W'(hit);   // wraps past 16 groups
    end
    return p;
  endfunction

  function automatic pauli_term_t make_term(logic [TERM_W-1:0] x, logic [TERM_W-1:0] z,
                                            logic [ID_W-1:0] id, logic new_set);
    pauli_term_t t;
    t.x       = x;
    t.z       = z;
    t.id      = id;
    t.new_set = new_set;
    return t;
  endfunction

  // random masks of the given style
  function automatic pauli_term_t random_term(term_style_e style, logic new_set);
    pauli_term_t t;
    int          q;
    int          pauli;
    int          shift;
    t.x       = '0;
    t.z       = '0;
    t.id      = ID_W'($urandom);
    t.new_set = new_set;
    case (style)
      MIX_SPARSE: begin
        repeat ($urandom_range(1, 3)) begin
          q     = $urandom_range(0, TERM_W - 1);
          pauli = $urandom_range(1, 3);   // X, Z or Y
          t.x[q] = pauli[0];
          t.z[q] = pauli[1];
        end
      end
      MIX_WINDOW: begin
        shift = $urandom_range(0, TERM_W - 4);
        t.x   = TERM_W'($urandom_range(0, 15)) << shift;
        t.z   = TERM_W'($urandom_range(0, 15)) << shift;
      end
      MIX_DENSE: begin
        t.x = TERM_W'($urandom);
        t.z = TERM_W'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: t.x = '0;
          1: t.x = '1;
          2: t.x = TERM_W'(1) << (TERM_W - 1);
          default: t.x = TERM_W'(1);
        endcase
        case ($urandom_range(0, 3))
          0: t.z = '0;
          1: t.z = '1;
          2: t.z = TERM_W'(1) << (TERM_W - 1);
          default: t.z = TERM_W'(1);
        endcase
      end
    endcase
    return t;
  endfunction

  // ------------------------------------------------------------------------
  // Source side: bursts of random length with random gaps in between. The
  // expectation is queued at the edge where the request is taken.
  // ------------------------------------------------------------------------
  task automatic send_term(input pauli_term_t t);
    int gap;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(0, 15);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.id, t.z, t.x};
    s_axis_tuser  <= t.new_set;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_placements.insert(pending_placements.size(), place_term(t));
    terms_sent++;
  endtask

  // ------------------------------------------------------------------------
  // Sink side: its own random stall pattern, plus a long hold-off whenever
  // the test thread asks for one.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left == 0 && hold_ack != hold_req) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) hold_ack++;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= (mode_left % 4 == 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker: every taken result against the oldest owed placement
  always @(posedge clk_i) begin : result_check
    placement_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_placements.size() == 0) begin
        $error("placement for term %0d with no request outstanding",
               m_axis_tdata[ID_W-1:0]);
        fail_count++;
      end else begin
        want = pending_placements.pop_front();
        check_field("placed_id",    want.id,       m_axis_tdata[ID_W-1:0]);
        check_field("group_index",  want.gidx,     m_axis_tdata[ID_W +: GIDX_W]);
        check_field("opened_group", want.opened,   m_axis_tuser[0]);
        check_field("overflow",     want.overflow, m_axis_tuser[1]);
      end
    end
  end

  // watchdog: too long with nothing moving on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // empty terms, all-one masks, single top-bit Paulis and a mid-run clear
  task automatic test_empty_and_extremes();
    logic [TERM_W-1:0] msb;
    msb = TERM_W'(1) << (TERM_W - 1);
    send_term(make_term('0,  '0,  16'h0000, 1'b1));   // empty, no group open: opens 0
    send_term(make_term('0,  '0,  16'hFFFF, 1'b0));   // empty: first open group
    send_term(make_term('1,  '1,  16'hAAAA, 1'b0));   // all-Y commutes with empty basis
    send_term(make_term('1,  '0,  16'h5555, 1'b0));   // all-X clashes: opens 1
    send_term(make_term('0,  '1,  16'h00FF, 1'b0));   // all-Z clashes both: opens 2
    send_term(make_term(msb, '0,  16'hFF00, 1'b1));   // clear, X on top qubit
    send_term(make_term('0,  msb, 16'h0F0F, 1'b0));   // Z there: clash
    send_term(make_term(msb, msb, 16'hF0F0, 1'b0));   // Y there: clashes with both
  endtask

  // staircase terms that each clash with every earlier group fill the table,
  // then the full-table overflow leaves the groups as they were
  task automatic test_table_overflow();
    logic [TERM_W-1:0] stair_x;
    for (int k = 0; k <= MAX_GROUPS; k++) begin
      stair_x = TERM_W'(1) << k;
      send_term(make_term(stair_x, stair_x - 1, ID_W'(16'h0100 + k), k == 0));
    end
    send_term(make_term('0, '0, 16'h0200, 1'b0));     // empty still fits group 0
    send_term(make_term(TERM_W'(1) << MAX_GROUPS, (TERM_W'(1) << MAX_GROUPS) - 1,
                        16'h0201, 1'b0));             // overflows again
  endtask

  // long sink hold-off while the source keeps offering back to back
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req++;
    for (int i = 0; i < 12; i++) send_term(random_term(MIX_SPARSE, i == 0));
    // source goes quiet while the hold-off runs out
    while (hold_ack != hold_req) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    gaps_on = 1'b1;
  endtask

  // well-formed sets (clear on the first term) of one style, with a few
  // off-style terms and stray clears mixed in as noise
  task automatic test_random_sets();
    term_style_e style;
    term_style_e pick;
    int          set_len;
    logic        clear;
    while (terms_sent < TERM_BUDGET) begin
      style   = term_style_e'($urandom_range(0, 3));
      set_len = $urandom_range(4, 40);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < set_len && terms_sent < TERM_BUDGET; i++) begin
        pick  = ($urandom_range(0, 7) == 0) ? term_style_e'($urandom_range(0, 3)) : style;
        clear = (i == 0) || ($urandom_range(0, 31) == 0);
        send_term(random_term(pick, clear));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_table_overflow();
    test_backpressure();
    test_random_sets();

    s_axis_tvalid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk_i);
    repeat (MAX_GROUPS + 4) @(posedge clk_i);   // catch any stray late result

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
